[hw/rtl/tsch_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TSCH scheduler package
// Types, codes and constants shared by the slot transmit scheduler.
// ----------------------------------------------------------------------------
package tsch_pkg;

  // Default depth of the new-packet and retransmit queues.
  localparam int QUEUE_DEPTH_DEF = 16;
  // Slot count that an out-of-range slotframe length falls back to.
  localparam int MAX_SLOTS = 64;

  // Stream word widths.
  localparam int S_TDATA_W = 72;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 64;
  localparam int M_TUSER_W = 3;

  // Configuration port widths.
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 64;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_SLOT_OWNED_MASK  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOTFRAME_LENGTH = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ATTEMPTS     = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SELF_ADDRESS     = 8'd3;

  // Reset values of the configuration registers.
  localparam logic [6:0] SLOTFRAME_LENGTH_RST = 7'd64;
  localparam logic [3:0] MAX_ATTEMPTS_RST     = 4'd3;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_ENQUEUE = 2'd1,
    REQ_FRAME   = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ACT_NONE         = 3'd0,
    ACT_SEND_NEW     = 3'd1,
    ACT_RESEND       = 3'd2,
    ACT_ACK_DELIVER  = 3'd3,
    ACT_DROPPED_FULL = 3'd4,
    ACT_ACK_CONSUMED = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_PURGE_RD,
    ST_PURGE_CMP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [15:0] handle;
    logic [15:0] seq;
    logic [15:0] dest;
    logic        ack;
  } new_entry_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [15:0] seq;
    logic [15:0] dest;
    logic        ack;
    logic [3:0]  count;
  } resend_entry_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] pkt_handle;
    logic [15:0] seq_num;
    logic [15:0] dest_addr;
    logic [15:0] src_addr;
    logic        ack_wanted;
    logic        frame_is_ack;
  } request_t;

  typedef struct packed {
    action_e     action;
    logic [3:0]  hop_channel;
    logic [15:0] out_handle;
    logic [15:0] out_dest;
    logic [15:0] out_seq;
    logic        out_ack_req;
    logic [3:0]  attempt_num;
    logic [5:0]  slot_now;
  } result_t;

endpackage
`default_nettype wire

[hw/rtl/tsch_slot_tx_scheduler_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TSCH slot transmit scheduler
// Channel-hopping MAC engine with a new-packet queue and a retransmit queue.
// ----------------------------------------------------------------------------
// Each input word is one request: a slot tick, an enqueue from the upper
// layer, or a frame from the radio; each request yields exactly one result
// word. A tick reports the hop channel and the slot index and, in an owned
// slot, sends the retransmit head first or else the new-queue head. Both
// queues are circular buffers in RAM with registered reads. A request moves
// through accept, head fetch, execute and result load in that order; the
// result load waits while the output register still holds an untaken word.
// An ack that is newer than the retransmit head purges one further entry per
// pass through the shared sequence compare, each pass a purge read state and
// a purge compare state between execute and result load. The input is ready
// again once the result sits in the output register, even if it has not
// been taken yet. Configuration writes are always accepted; they must only
// be issued while no request is in flight.
// ----------------------------------------------------------------------------
module tsch_slot_tx_scheduler_unit #(
  parameter int QUEUE_DEPTH = tsch_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Request stream.
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: pkt_handle[15:0], seq_num[31:16], dest_addr[47:32],
  //        src_addr[63:48], ack_wanted[64], zero fill[71:65]
  input  wire logic [tsch_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // tuser: req_type[1:0], frame_is_ack[2]
  input  wire logic [tsch_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  // Result stream.
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // tdata: hop_channel[3:0], out_handle[19:4], out_dest[35:20],
  //        out_seq[51:36], out_ack_req[52], attempt_num[56:53],
  //        slot_now[62:57], zero fill[63]
  output logic [tsch_pkg::M_TDATA_W-1:0]        m_axis_tdata,
  // tuser: action[2:0]
  output logic [tsch_pkg::M_TUSER_W-1:0]        m_axis_tuser,
  // Configuration write channel.
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [tsch_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [tsch_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import tsch_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [6:0]       MAX_LEN  = 7'(MAX_SLOTS);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  // Configuration registers.
  logic [63:0] owned_mask_q;
  logic [6:0]  sf_len_q;
  logic [3:0]  max_att_q;
  logic [15:0] self_addr_q;

  // Sequencer and request capture.
  state_e   state_q, state_d;
  request_t req_q;

  // Slot counters.
  logic [5:0] slot_q, slot_d;
  logic [3:0] asn_q, asn_d;
  logic [3:0] frame_q, frame_d;

  // Queues.
  new_entry_t    new_mem [QUEUE_DEPTH];
  resend_entry_t res_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] new_head_q, new_tail_q, res_head_q, res_tail_q;
  logic [CNT_W-1:0] new_fill_q, res_fill_q;
  new_entry_t    new_rd_q;
  resend_entry_t res_rd_q;

  // Result staging and output register.
  result_t res_d, res_q, out_q;
  logic    out_valid_q, out_valid_d, out_load;

  // Datapath controls produced by the execute logic.
  logic          new_push, new_pop, res_push, res_pop;
  new_entry_t    new_wdata;
  resend_entry_t res_wdata;
  logic          slot_adv, purge_more, res_upd;
  logic          seq_eq, seq_gt, owned;
  logic [6:0]    len_eff;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owned_mask_q <= '0;
      sf_len_q     <= SLOTFRAME_LENGTH_RST;
      max_att_q    <= MAX_ATTEMPTS_RST;
      self_addr_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_SLOT_OWNED_MASK:  owned_mask_q <= cfg_data_i;
        REG_SLOTFRAME_LENGTH: sf_len_q     <= cfg_data_i[6:0];
        REG_MAX_ATTEMPTS:     max_att_q    <= cfg_data_i[3:0];
        REG_SELF_ADDRESS:     self_addr_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Request capture on acceptance.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_q.req_type     <= s_axis_tuser[1:0];
      req_q.frame_is_ack <= s_axis_tuser[2];
      req_q.pkt_handle   <= s_axis_tdata[15:0];
      req_q.seq_num      <= s_axis_tdata[31:16];
      req_q.dest_addr    <= s_axis_tdata[47:32];
      req_q.src_addr     <= s_axis_tdata[63:48];
      req_q.ack_wanted   <= s_axis_tdata[64];
    end
  end

  // The shared compare unit: request sequence number against the
  // retransmit head, used for the first ack check and every purge pass.
  assign seq_eq = (req_q.seq_num == res_rd_q.seq);
  assign seq_gt = (req_q.seq_num >  res_rd_q.seq);

  assign owned   = owned_mask_q[slot_q];
  assign len_eff = (sf_len_q == 7'd0 || sf_len_q > MAX_LEN) ? MAX_LEN : sf_len_q;

  // Execute logic: queue operations, counter advance and result contents.
  always_comb begin
    new_push   = 1'b0;
    new_pop    = 1'b0;
    res_push   = 1'b0;
    res_pop    = 1'b0;
    new_wdata  = '{handle: req_q.pkt_handle, seq: req_q.seq_num,
                   dest: req_q.dest_addr, ack: req_q.ack_wanted};
    res_wdata  = res_rd_q;
    slot_adv   = 1'b0;
    purge_more = 1'b0;
    res_upd    = 1'b0;
    res_d      = '0;
    res_d.action = ACT_NONE;

    case (state_q)
      ST_EXEC: begin
        res_upd = 1'b1;
        case (req_q.req_type)
          REQ_TICK: begin
            slot_adv          = 1'b1;
            res_d.hop_channel = asn_q + frame_q;
            res_d.slot_now    = slot_q;
            if (owned && res_fill_q != '0) begin
              res_pop           = 1'b1;
              res_d.action      = ACT_RESEND;
              res_d.out_handle  = res_rd_q.handle;
              res_d.out_dest    = res_rd_q.dest;
              res_d.out_seq     = res_rd_q.seq;
              res_d.out_ack_req = res_rd_q.ack;
              res_d.attempt_num = res_rd_q.count;
              if (res_rd_q.count < max_att_q) begin
                // Requeue at the tail; the popped slot makes room.
                res_push        = 1'b1;
                res_wdata.count = res_rd_q.count + 4'd1;
              end
            end else if (owned && new_fill_q != '0) begin
              new_pop           = 1'b1;
              res_d.action      = ACT_SEND_NEW;
              res_d.out_handle  = new_rd_q.handle;
              res_d.out_dest    = new_rd_q.dest;
              res_d.out_seq     = new_rd_q.seq;
              res_d.out_ack_req = new_rd_q.ack;
              if (new_rd_q.ack && max_att_q != 4'd0 && res_fill_q != FULL_CNT) begin
                res_push  = 1'b1;
                res_wdata = '{handle: new_rd_q.handle, seq: new_rd_q.seq,
                              dest: new_rd_q.dest, ack: new_rd_q.ack, count: 4'd1};
              end
            end
          end
          REQ_ENQUEUE: begin
            if (new_fill_q == FULL_CNT) begin
              res_d.action     = ACT_DROPPED_FULL;
              res_d.out_handle = req_q.pkt_handle;
              res_d.out_dest   = req_q.dest_addr;
              res_d.out_seq    = req_q.seq_num;
            end else begin
              new_push = 1'b1;
            end
          end
          REQ_FRAME: begin
            if (req_q.dest_addr == self_addr_q) begin
              if (req_q.frame_is_ack) begin
                if (res_fill_q != '0 && (seq_eq || seq_gt)) begin
                  res_pop       = 1'b1;
                  res_d.action  = ACT_ACK_CONSUMED;
                  res_d.out_seq = req_q.seq_num;
                  // A newer ack keeps popping older heads.
                  purge_more    = seq_gt && (res_fill_q > CNT_W'(1));
                end
              end else begin
                res_d.action     = ACT_ACK_DELIVER;
                res_d.out_handle = req_q.pkt_handle;
                res_d.out_dest   = req_q.src_addr;
                res_d.out_seq    = req_q.seq_num;
              end
            end
          end
          default: ;
        endcase
      end
      ST_PURGE_CMP: begin
        if (res_fill_q != '0 && seq_gt) begin
          res_pop    = 1'b1;
          purge_more = (res_fill_q > CNT_W'(1));
        end
      end
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (s_axis_tvalid) state_d = ST_FETCH;
      ST_FETCH:     state_d = ST_EXEC;
      ST_EXEC:      state_d = purge_more ? ST_PURGE_RD : ST_DONE;
      ST_PURGE_RD:  state_d = ST_PURGE_CMP;
      ST_PURGE_CMP: state_d = purge_more ? ST_PURGE_RD : ST_DONE;
      ST_DONE:      if (out_load) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // The result moves to the output register once that register is free.
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
  assign out_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  // Slot counters.
  always_comb begin
    slot_d  = slot_q;
    asn_d   = asn_q;
    frame_d = frame_q;
    if (slot_adv) begin
      asn_d = asn_q + 4'd1;
      if ({1'b0, slot_q} + 7'd1 >= len_eff) begin
        slot_d  = '0;
        frame_d = frame_q + 4'd1;
      end else begin
        slot_d = slot_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      asn_q       <= '0;
      frame_q     <= '0;
      out_valid_q <= 1'b0;
      new_head_q  <= '0;
      new_tail_q  <= '0;
      new_fill_q  <= '0;
      res_head_q  <= '0;
      res_tail_q  <= '0;
      res_fill_q  <= '0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      asn_q       <= asn_d;
      frame_q     <= frame_d;
      out_valid_q <= out_valid_d;
      if (new_push) new_tail_q <= ptr_inc(new_tail_q);
      if (new_pop)  new_head_q <= ptr_inc(new_head_q);
      new_fill_q <= new_fill_q + CNT_W'(new_push) - CNT_W'(new_pop);
      if (res_push) res_tail_q <= ptr_inc(res_tail_q);
      if (res_pop)  res_head_q <= ptr_inc(res_head_q);
      res_fill_q <= res_fill_q + CNT_W'(res_push) - CNT_W'(res_pop);
    end
  end

  // Queue memories with registered head reads.
  always_ff @(posedge clk_i) begin
    if (new_push) new_mem[new_tail_q] <= new_wdata;
    new_rd_q <= new_mem[new_head_q];
  end

  always_ff @(posedge clk_i) begin
    if (res_push) res_mem[res_tail_q] <= res_wdata;
    res_rd_q <= res_mem[res_head_q];
  end

  // Result staging and output payload.
  always_ff @(posedge clk_i) begin
    if (res_upd)  res_q <= res_d;
    if (out_load) out_q <= res_q;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.action;
  assign m_axis_tdata  = {1'b0, out_q.slot_now, out_q.attempt_num, out_q.out_ack_req,
                          out_q.out_seq, out_q.out_dest, out_q.out_handle,
                          out_q.hop_channel};

endmodule
`default_nettype wire
